// File: src/distinct_prime_factorizer_unit_macros.svh
// ----------------------------------------------------------------------------
// distinct_prime_factorizer_unit_macros.svh
// Assertion macros used by the factorizer RTL (dpf_back).
// ----------------------------------------------------------------------------
`ifndef DISTINCT_PRIME_FACTORIZER_UNIT_MACROS_SVH
`define DISTINCT_PRIME_FACTORIZER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define DPF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define DPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/dpf_pkg.sv
// ----------------------------------------------------------------------------
// dpf_pkg
// Widths, queue items and state codes of the distinct prime factorizer.
// ----------------------------------------------------------------------------
package dpf_pkg;

  localparam int VALUE_W  = 32;
  localparam int D_W      = VALUE_W / 2 + 1;
  localparam int CNT_W    = $clog2(VALUE_W);
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               trivial;
  } job_t;

  typedef struct packed {
    logic [VALUE_W-1:0] factor;
    logic               has_factor;
    logic               last;
  } result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_FOUND,
    B_END,
    B_TAIL,
    B_TRIV
  } back_state_e;

  typedef enum logic {
    M_TRIAL,
    M_STRIP
  } div_mode_e;

endpackage

// File: src/dpf_div.sv
// ----------------------------------------------------------------------------
// dpf_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dpf_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [dpf_pkg::VALUE_W-1:0]  dividend_i,
  input  logic [dpf_pkg::D_W-1:0]      divisor_i,
  output dpf_pkg::div_stat_t           stat_o,
  output logic [dpf_pkg::VALUE_W-1:0]  quot_o,
  output logic [dpf_pkg::D_W-1:0]      rem_o
);

  logic                        busy_q;
  logic                        done_q;
  logic [dpf_pkg::CNT_W-1:0]   cnt_q;
  logic [dpf_pkg::VALUE_W-1:0] quot_q;
  logic [dpf_pkg::D_W-1:0]     rem_q;
  logic [dpf_pkg::D_W-1:0]     dvs_q;
  logic [dpf_pkg::D_W:0]       trial;
  logic [dpf_pkg::D_W:0]       diff;
  logic                        ge;
  logic [dpf_pkg::D_W-1:0]     rem_d;

  always_comb begin
    trial = {rem_q, quot_q[dpf_pkg::VALUE_W-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? diff[dpf_pkg::D_W-1:0] : trial[dpf_pkg::D_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + dpf_pkg::CNT_W'(1);
      if (cnt_q == dpf_pkg::CNT_W'(dpf_pkg::VALUE_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[dpf_pkg::VALUE_W-2:0], ge};
      rem_q  <= rem_d;
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// File: src/dpf_front.sv
// ----------------------------------------------------------------------------
// dpf_front
// Input side: accept values, flag zero and one, buffer jobs for the engine.
// ----------------------------------------------------------------------------
module dpf_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [dpf_pkg::VALUE_W-1:0] value_i,
  output logic                        job_valid_o,
  input  logic                        job_ready_i,
  output dpf_pkg::job_t               job_o
);

  dpf_pkg::job_t               mem_q [dpf_pkg::QDEPTH];
  logic [dpf_pkg::QPTR_W-1:0]  wr_ptr_q;
  logic [dpf_pkg::QPTR_W-1:0]  rd_ptr_q;
  logic [dpf_pkg::QCNT_W-1:0]  cnt_q;
  logic                        do_wr;
  logic                        do_rd;

  always_comb begin
    full        = cnt_q == dpf_pkg::QCNT_W'(dpf_pkg::QDEPTH);
    job_valid_o = cnt_q != '0;
    do_wr       = push && !full;
    do_rd       = job_ready_i && job_valid_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + dpf_pkg::QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + dpf_pkg::QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + dpf_pkg::QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - dpf_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= '{value: value_i,
                           trivial: value_i < dpf_pkg::VALUE_W'(2)};
    end
  end

  assign job_o = mem_q[rd_ptr_q];

endmodule

// File: src/dpf_outq.sv
// ----------------------------------------------------------------------------
// dpf_outq
// Result queue between the engine and the consumer.
// ----------------------------------------------------------------------------
module dpf_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dpf_pkg::result_t  data_i,
  output logic              full_o,
  input  logic              pop,
  output logic              empty,
  output dpf_pkg::result_t  data_o
);

  dpf_pkg::result_t            mem_q [dpf_pkg::QDEPTH];
  logic [dpf_pkg::QPTR_W-1:0]  wr_ptr_q;
  logic [dpf_pkg::QPTR_W-1:0]  rd_ptr_q;
  logic [dpf_pkg::QCNT_W-1:0]  cnt_q;
  logic                        do_wr;
  logic                        do_rd;

  always_comb begin
    full_o = cnt_q == dpf_pkg::QCNT_W'(dpf_pkg::QDEPTH);
    empty  = cnt_q == '0;
    do_wr  = push_i && !full_o;
    do_rd  = pop && !empty;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + dpf_pkg::QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + dpf_pkg::QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + dpf_pkg::QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - dpf_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o = mem_q[rd_ptr_q];

endmodule

// File: src/dpf_back.sv
// ----------------------------------------------------------------------------
// dpf_back
// Trial division sequencer around a shared iterative divider.
// ----------------------------------------------------------------------------
`include "distinct_prime_factorizer_unit_macros.svh"

module dpf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  dpf_pkg::job_t     job_i,
  output logic              out_push_o,
  output dpf_pkg::result_t  out_data_o,
  input  logic              out_full_i
);

  dpf_pkg::back_state_e        state_q, state_d;
  dpf_pkg::div_mode_e          mode_q, mode_d;
  logic [dpf_pkg::VALUE_W-1:0] rem_q, rem_d;
  logic [dpf_pkg::D_W-1:0]     d_q, d_d;
  logic [dpf_pkg::D_W-1:0]     pend_q, pend_d;
  logic                        has_pend_q, has_pend_d;
  logic                        div_start;
  dpf_pkg::div_stat_t          div_stat;
  logic [dpf_pkg::VALUE_W-1:0] div_quot;
  logic [dpf_pkg::D_W-1:0]     div_rem;

  dpf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rem_d),
    .divisor_i  (d_d),
    .stat_o     (div_stat),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dpf_pkg::B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    rem_q      <= rem_d;
    d_q        <= d_d;
    pend_q     <= pend_d;
    has_pend_q <= has_pend_d;
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    rem_d       = rem_q;
    d_d         = d_q;
    pend_d      = pend_q;
    has_pend_d  = has_pend_q;
    div_start   = 1'b0;
    job_ready_o = 1'b0;
    out_push_o  = 1'b0;
    out_data_o  = '0;
    case (state_q)
      dpf_pkg::B_IDLE: begin
        job_ready_o = 1'b1;
        if (job_valid_i) begin
          rem_d      = job_i.value;
          d_d        = dpf_pkg::D_W'(2);
          has_pend_d = 1'b0;
          mode_d     = dpf_pkg::M_TRIAL;
          if (job_i.trivial) begin
            state_d = dpf_pkg::B_TRIV;
          end else begin
            div_start = 1'b1;
            state_d   = dpf_pkg::B_DIV;
          end
        end
      end
      dpf_pkg::B_DIV: begin
        if (div_stat.done) begin
          if (mode_q == dpf_pkg::M_TRIAL) begin
            if (dpf_pkg::VALUE_W'(d_q) > div_quot) begin
              state_d = dpf_pkg::B_END;
            end else if (div_rem == '0) begin
              state_d = dpf_pkg::B_FOUND;
            end else begin
              d_d       = d_q + dpf_pkg::D_W'(1);
              div_start = 1'b1;
            end
          end else begin
            if (div_rem == '0) begin
              rem_d = div_quot;
            end else begin
              d_d    = d_q + dpf_pkg::D_W'(1);
              mode_d = dpf_pkg::M_TRIAL;
            end
            div_start = 1'b1;
          end
        end
      end
      dpf_pkg::B_FOUND: begin
        if (!(has_pend_q && out_full_i)) begin
          out_push_o = has_pend_q;
          out_data_o = '{factor: dpf_pkg::VALUE_W'(pend_q), has_factor: 1'b1, last: 1'b0};
          pend_d     = d_q;
          has_pend_d = 1'b1;
          rem_d      = div_quot;
          mode_d     = dpf_pkg::M_STRIP;
          div_start  = 1'b1;
          state_d    = dpf_pkg::B_DIV;
        end
      end
      dpf_pkg::B_END: begin
        if (!out_full_i) begin
          out_push_o = 1'b1;
          if (rem_q > dpf_pkg::VALUE_W'(1)) begin
            if (has_pend_q) begin
              out_data_o = '{factor: dpf_pkg::VALUE_W'(pend_q), has_factor: 1'b1,
                             last: 1'b0};
              state_d    = dpf_pkg::B_TAIL;
            end else begin
              out_data_o = '{factor: rem_q, has_factor: 1'b1, last: 1'b1};
              state_d    = dpf_pkg::B_IDLE;
            end
          end else begin
            out_data_o = '{factor: dpf_pkg::VALUE_W'(pend_q), has_factor: 1'b1,
                           last: 1'b1};
            state_d    = dpf_pkg::B_IDLE;
          end
        end
      end
      dpf_pkg::B_TAIL: begin
        if (!out_full_i) begin
          out_push_o = 1'b1;
          out_data_o = '{factor: rem_q, has_factor: 1'b1, last: 1'b1};
          state_d    = dpf_pkg::B_IDLE;
        end
      end
      dpf_pkg::B_TRIV: begin
        if (!out_full_i) begin
          out_push_o = 1'b1;
          out_data_o = '{factor: '0, has_factor: 1'b0, last: 1'b1};
          state_d    = dpf_pkg::B_IDLE;
        end
      end
      default: begin
        state_d = dpf_pkg::B_IDLE;
      end
    endcase
  end

  `DPF_ASSERT_IMP(a_push_room, out_push_o, !out_full_i, "result pushed into a full queue")
  `DPF_ASSERT_IMP(a_start_idle, div_start, !div_stat.busy, "divider restarted while busy")
  `DPF_ASSERT_IMP(a_divisor_min, state_q == dpf_pkg::B_DIV || state_q == dpf_pkg::B_FOUND, d_q >= dpf_pkg::D_W'(2), "trial divisor below two")
  `DPF_ASSERT_NEXT(a_strip_shrinks, state_q == dpf_pkg::B_DIV && div_stat.done && mode_q == dpf_pkg::M_STRIP && div_rem == '0, rem_q < $past(rem_q), "stripping did not reduce the value")

endmodule

// File: src/distinct_prime_factorizer_unit.sv
// ----------------------------------------------------------------------------
// distinct_prime_factorizer_unit
// Distinct prime factors of a 32-bit value by trial division.
//
// Input channel: drive value_i with push high; the value is taken on a clock
// edge where full is low. A two-entry job queue lets a few values wait.
// Result channel: while empty is low, factor_o/has_factor_o/last_o show the
// oldest result; pop high on a clock edge takes it. Each value yields its
// distinct primes in ascending order, last_o set on the final one; zero and
// one yield a single result with has_factor_o low.
// Every trial divisor costs one pass of a shared one-bit-per-cycle divider;
// a value needs about sqrt(n) divisors plus one extra pass for each time a
// prime factor divides it. Values are worked one at a time.
// Reset clears both queues and returns the engine to idle. When the consumer
// stalls, the result queue fills, the engine holds, and full rises once the
// job queue is also taken up.
// ----------------------------------------------------------------------------
module distinct_prime_factorizer_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [dpf_pkg::VALUE_W-1:0] value_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [dpf_pkg::VALUE_W-1:0] factor_o,
  output logic                        has_factor_o,
  output logic                        last_o
);

  logic              job_valid;
  logic              job_ready;
  dpf_pkg::job_t     job;
  logic              out_push;
  logic              out_full;
  dpf_pkg::result_t  out_data;
  dpf_pkg::result_t  head;

  dpf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .value_i     (value_i),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  dpf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .out_push_o  (out_push),
    .out_data_o  (out_data),
    .out_full_i  (out_full)
  );

  dpf_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .data_i (out_data),
    .full_o (out_full),
    .pop    (pop),
    .empty  (empty),
    .data_o (head)
  );

  assign factor_o     = head.factor;
  assign has_factor_o = head.has_factor;
  assign last_o       = head.last;

endmodule
